FILE: src/chrr_pkg.sv
// Types, constants and the mixing round of the ranged counter-hash generator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package chrr_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW  = 2'd1;

    localparam logic [WORD_W-1:0] MIX_ADD = 32'd314159265;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    typedef struct packed {
        logic signed [WORD_W-1:0] min_value;
        logic signed [WORD_W-1:0] max_value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] random_value;
    } rsp_t;

    typedef struct packed {
        logic [WORD_W-1:0] min_value;
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] mask;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [2*WORD_W-1:0] mix_round(input logic [2*WORD_W-1:0] s);
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
        hi = s[2*WORD_W-1:WORD_W];
        lo = s[WORD_W-1:0];
        hi = {hi[28:0], hi[31:29]};
        lo = lo + MIX_ADD;
        hi = hi + {lo[24:0], 7'b0};
        lo = lo ^ hi;
        hi = hi ^ {lo[15:0], lo[31:16]};
        return {hi, lo};
    endfunction

endpackage

`default_nettype wire

FILE: src/chrr_stream_if.sv
// Valid/ready channel carrying one payload beat.
// Payload type is set at instantiation; no package dependency.
`default_nettype none

interface chrr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/chrr_front.sv
// Request front end: accepts a beat, computes range width and draw mask.
// Depends on chrr_pkg and chrr_stream_if.
`default_nettype none

module chrr_front (
    chrr_stream_if.sink          req,
    input  chrr_pkg::q_status_t  q_status,
    output logic                 push,
    output chrr_pkg::job_t       job
);
    logic [chrr_pkg::WORD_W-1:0] width;
    logic [chrr_pkg::WORD_W-1:0] smear;

    always_comb
    begin
        width = chrr_pkg::WORD_W'(req.data.max_value) - chrr_pkg::WORD_W'(req.data.min_value);
        smear = width;
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
        job.min_value = chrr_pkg::WORD_W'(req.data.min_value);
        job.width     = width;
        job.mask      = smear | chrr_pkg::WORD_W'(1);
    end

    assign req.ready = !q_status.full;
    assign push      = req.valid && !q_status.full;

endmodule

`default_nettype wire

FILE: src/chrr_queue.sv
// Short job queue between front end and draw engine.
// Depends on chrr_pkg.
`default_nettype none

module chrr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  chrr_pkg::job_t       push_job,
    input  logic                 pop,
    output chrr_pkg::job_t       head_job,
    output chrr_pkg::q_status_t  status
);
    chrr_pkg::job_t               entry_reg [chrr_pkg::QUEUE_DEPTH];
    logic [chrr_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [chrr_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [chrr_pkg::QCNT_W-1:0]  count_reg;
    logic [chrr_pkg::QCNT_W-1:0]  count_next;

    assign status.full  = (count_reg == chrr_pkg::QCNT_W'(chrr_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + chrr_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - chrr_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + chrr_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + chrr_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

FILE: src/chrr_back.sv
// Draw engine: seed registers, 64-bit counter, iterative mixer, rejection
// loop and output register. Depends on chrr_pkg and chrr_stream_if.
`default_nettype none

module chrr_back #(
    parameter int unsigned MIX_ROUNDS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [chrr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [chrr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  chrr_pkg::job_t                    head_job,
    input  chrr_pkg::q_status_t               q_status,
    output logic                              pop,
    chrr_stream_if.source                     rsp
);
    localparam int unsigned RND_W = (MIX_ROUNDS > 1) ? $clog2(MIX_ROUNDS) : 1;
    localparam int unsigned W     = chrr_pkg::WORD_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MIX   = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [RND_W-1:0] round_reg;
    logic [W-1:0]     seed_hi_reg;
    logic [W-1:0]     seed_lo_reg;
    logic [2*W-1:0]   counter_reg;
    logic [2*W-1:0]   counter_inc;
    logic [2*W-1:0]   mix_reg;
    chrr_pkg::job_t   job_reg;
    logic [W-1:0]     res_reg;
    logic             out_valid_reg;
    logic [W-1:0]     pick;
    logic             reject;
    logic             slot_free;

    assign counter_inc = counter_reg + (2*W)'(1);
    assign pick        = mix_reg[2*W-1:W] & job_reg.mask;
    assign reject      = (pick > job_reg.width);
    assign slot_free   = !out_valid_reg || rsp.ready;
    assign pop         = (state_reg == S_IDLE) && !q_status.empty;

    assign rsp.valid             = out_valid_reg;
    assign rsp.data.random_value = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (!q_status.empty)
                    state_next = S_MIX;
            S_MIX:
                if (round_reg == RND_W'(MIX_ROUNDS - 1))
                    state_next = S_CHECK;
            S_CHECK:
                state_next = reject ? S_MIX : S_OUT;
            S_OUT:
                if (slot_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_reg     <= '0;
            seed_hi_reg   <= '0;
            seed_lo_reg   <= '0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == chrr_pkg::REG_SEED_HIGH)
            begin
                seed_hi_reg <= cfg_data;
                counter_reg <= {cfg_data, seed_lo_reg};
            end
            else if (cfg_we && cfg_index == chrr_pkg::REG_SEED_LOW)
            begin
                seed_lo_reg <= cfg_data;
                counter_reg <= {seed_hi_reg, cfg_data};
            end
            else if (pop || (state_reg == S_CHECK && reject))
                counter_reg <= counter_inc;

            if (state_reg == S_MIX)
                round_reg <= round_reg + RND_W'(1);
            if (state_next == S_CHECK)
                round_reg <= '0;

            if (state_reg == S_OUT && slot_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head_job;
        if (pop || (state_reg == S_CHECK && reject))
            mix_reg <= counter_inc;
        else if (state_reg == S_MIX)
            mix_reg <= chrr_pkg::mix_round(mix_reg);
        if (state_reg == S_OUT && slot_free)
            res_reg <= pick + job_reg.min_value;
    end

endmodule

`default_nettype wire

FILE: src/counter_hash_ranged_rng.sv
// Ranged uniform generator from a hashed 64-bit counter.
// Jobs are drawn one at a time by the one-round-per-cycle mixer; the queue takes requests while not full.
// Reset: seeds and counter clear to zero; queue and output empty; no clearing pass.
// Depends on chrr_pkg, chrr_stream_if, chrr_front, chrr_queue, chrr_back.
`default_nettype none

module counter_hash_ranged_rng #(
    parameter int unsigned MIX_ROUNDS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    chrr_stream_if.sink                       req,
    chrr_stream_if.source                     rsp,
    input  logic                              cfg_we,
    input  logic [chrr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [chrr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    logic                 push;
    logic                 pop;
    chrr_pkg::job_t       push_job;
    chrr_pkg::job_t       head_job;
    chrr_pkg::q_status_t  q_status;

    chrr_front u_front (
        .req      (req),
        .q_status (q_status),
        .push     (push),
        .job      (push_job)
    );

    chrr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    chrr_back #(
        .MIX_ROUNDS (MIX_ROUNDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Testbench for the ranged counter-hash generator: directed bounds table, then random
// bounds under several seed settings, checked beat by beat against a local predictor.
// Depends on chrr_pkg, chrr_stream_if and counter_hash_ranged_rng.
`default_nettype none

module tb;
    localparam int unsigned WORD_W     = chrr_pkg::WORD_W;
    localparam int unsigned CFG_IDX_W  = chrr_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W = chrr_pkg::CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int unsigned HASH_ROUNDS     = 10;
    localparam int unsigned ITEMS_PER_PHASE = 50;
    localparam int unsigned NUM_PHASES      = 8;
    localparam int unsigned STALL_LIMIT     = 20000;
    localparam int unsigned DRAIN_TAIL      = 64;
    localparam int unsigned NUM_DIR_ROWS    = 21;

    localparam logic [WORD_W-1:0] INT_MIN_W = 32'h8000_0000;
    localparam logic [WORD_W-1:0] INT_MAX_W = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic              known;
        logic [WORD_W-1:0] value;
    } bounds_row_t;

    localparam bounds_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
        '{32'd0,          32'd0,          1'b1, 32'd0},
        '{INT_MIN_W,      INT_MIN_W,      1'b1, INT_MIN_W},
        '{INT_MAX_W,      INT_MAX_W,      1'b1, INT_MAX_W},
        '{ALL_ONES,       ALL_ONES,       1'b1, ALL_ONES},
        '{INT_MIN_W,      INT_MAX_W,      1'b0, 32'd0},
        '{32'd0,          ALL_ONES,       1'b0, 32'd0},
        '{INT_MAX_W,      INT_MIN_W,      1'b0, 32'd0},
        '{32'd1,          32'd0,          1'b0, 32'd0},
        '{32'd0,          32'd1,          1'b0, 32'd0},
        '{32'd0,          INT_MAX_W,      1'b0, 32'd0},
        '{INT_MIN_W,      ALL_ONES,       1'b0, 32'd0},
        '{ALL_ONES,       32'd0,          1'b0, 32'd0},
        '{32'd0,          32'd2,          1'b0, 32'd0},
        '{32'd0,          32'd3,          1'b0, 32'd0},
        '{32'd0,          32'd4,          1'b0, 32'd0},
        '{32'd100,        32'd355,        1'b0, 32'd0},
        '{32'd100,        32'd356,        1'b0, 32'd0},
        '{INT_MIN_W,      32'd0,          1'b0, 32'd0},
        '{32'hAAAA_AAAA,  32'h5555_5555,  1'b0, 32'd0},
        '{32'h7FFF_FFFE,  INT_MAX_W,      1'b0, 32'd0},
        '{INT_MIN_W,      32'h8000_0001,  1'b0, 32'd0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    chrr_stream_if #(.payload_t(chrr_pkg::req_t)) req_ch ();
    chrr_stream_if #(.payload_t(chrr_pkg::rsp_t)) rsp_ch ();

    counter_hash_ranged_rng #(.MIX_ROUNDS(HASH_ROUNDS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [WORD_W-1:0]   seed_high;
    logic [WORD_W-1:0]   seed_low;
    logic [2*WORD_W-1:0] ctr_state;

    logic signed [WORD_W-1:0] pending_values [$];
    logic signed [WORD_W-1:0] want_value;

    int          src_idle_pct;
    int          snk_idle_pct;
    int unsigned mismatches   = 0;
    int unsigned stall_cycles = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [WORD_W-1:0] hash_draw();
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] l;
        ctr_state = ctr_state + (2*WORD_W)'(1);
        h = ctr_state[2*WORD_W-1:WORD_W];
        l = ctr_state[WORD_W-1:0];
        for (int r = 0; r < HASH_ROUNDS; r++)
        begin
            h = {h[28:0], h[31:29]};
            l = l + chrr_pkg::MIX_ADD;
            h = h + (l << 7);
            l = l ^ h;
            h = h ^ {l[15:0], l[31:16]};
        end
        return h;
    endfunction

    function automatic logic [WORD_W-1:0] next_ranged_value(input logic [WORD_W-1:0] lo_b,
                                                             input logic [WORD_W-1:0] hi_b);
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] pick;
        width = hi_b - lo_b;
        mask  = 32'd1;
        while (mask < width)
            mask = {mask[WORD_W-2:0], 1'b1};
        pick = hash_draw() & mask;
        while (pick > width)
            pick = hash_draw() & mask;
        return pick + lo_b;
    endfunction

    function automatic void seed_write_model(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            chrr_pkg::REG_SEED_HIGH:
            begin
                seed_high = data;
                ctr_state = {seed_high, seed_low};
            end
            chrr_pkg::REG_SEED_LOW:
            begin
                seed_low  = data;
                ctr_state = {seed_high, seed_low};
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] edge_word();
        case ($urandom_range(0, 4))
            0:       return INT_MIN_W;
            1:       return INT_MAX_W;
            2:       return 32'd0;
            3:       return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_bounds(output logic [WORD_W-1:0] lo_b, output logic [WORD_W-1:0] hi_b);
        int unsigned k;
        logic [WORD_W-1:0] w;
        lo_b = $urandom;
        case ($urandom_range(0, 6))
            0: hi_b = $urandom;
            1: hi_b = lo_b + $urandom_range(0, 20);
            2:
            begin
                k    = $urandom_range(0, 31);
                w    = (32'd1 << k) + $urandom_range(0, 2) - 1;
                hi_b = lo_b + w;
            end
            3: hi_b = lo_b - $urandom_range(1, 1000);
            4: hi_b = lo_b;
            5:
            begin
                lo_b = edge_word();
                hi_b = edge_word();
            end
            default: hi_b = lo_b - 1;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        seed_write_model(idx, data);
    endtask

    task automatic send_bounds(input logic [WORD_W-1:0] lo_b, input logic [WORD_W-1:0] hi_b,
                               input logic known, input logic [WORD_W-1:0] value);
        logic [WORD_W-1:0] predicted;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct)
                @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= chrr_pkg::req_t'({lo_b, hi_b});
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = next_ranged_value(lo_b, hi_b);
        pending_values.push_back(known ? value : predicted);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_values.size() == 0)
                begin
                    $error("random_value: expected none, got %0d", rsp_ch.data.random_value);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want_value = pending_values.pop_front();
                    if (rsp_ch.data.random_value !== want_value)
                    begin
                        $error("random_value: expected %0d, got %0d",
                               want_value, rsp_ch.data.random_value);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        logic [WORD_W-1:0] lo_b;
        logic [WORD_W-1:0] hi_b;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = chrr_pkg::REG_SEED_HIGH;
        cfg_data     = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        src_idle_pct = 14;
        snk_idle_pct = 78;
        seed_high    = '0;
        seed_low     = '0;
        ctr_state    = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR_ROWS; i++)
            send_bounds(DIR_ROWS[i].lo, DIR_ROWS[i].hi, DIR_ROWS[i].known, DIR_ROWS[i].value);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    write_reg(chrr_pkg::REG_SEED_HIGH, ALL_ONES);
                    write_reg(chrr_pkg::REG_SEED_LOW, ALL_ONES);
                end
                1:
                begin
                    write_reg(REG_SPARE_2, $urandom);
                    write_reg(REG_SPARE_3, $urandom);
                end
                2: write_reg(chrr_pkg::REG_SEED_LOW, 32'hFFFF_FFF0);
                3:
                begin
                    write_reg(chrr_pkg::REG_SEED_HIGH, 32'd0);
                    write_reg(chrr_pkg::REG_SEED_LOW, 32'd0);
                end
                4:
                begin
                    write_reg(chrr_pkg::REG_SEED_HIGH, $urandom);
                    write_reg(chrr_pkg::REG_SEED_LOW, $urandom);
                end
                5:
                begin
                    write_reg(chrr_pkg::REG_SEED_HIGH, $urandom);
                    write_reg(chrr_pkg::REG_SEED_LOW, ALL_ONES - $urandom_range(0, 8));
                end
                6: write_reg(chrr_pkg::REG_SEED_HIGH, $urandom);
                default:
                begin
                    write_reg(chrr_pkg::REG_SEED_LOW, $urandom);
                    write_reg(chrr_pkg::REG_SEED_HIGH, $urandom);
                    write_reg(REG_SPARE_3, $urandom);
                end
            endcase
            cfg_we <= 1'b0;
            if (p >= 6)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else if (p >= 3)
            begin
                src_idle_pct = 78;
                snk_idle_pct = 14;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick_bounds(lo_b, hi_b);
                send_bounds(lo_b, hi_b, 1'b0, '0);
            end
        end

        drain();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0 && pending_values.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
src/chrr_pkg.sv
src/chrr_stream_if.sv
src/chrr_front.sv
src/chrr_queue.sv
src/chrr_back.sv
src/counter_hash_ranged_rng.sv
verif/tb.sv
